// File: hdl/b32d_pkg.sv
package b32d_pkg;

    localparam int          COUNT_BITS_DEF = 16;
    localparam logic [15:0] LIMIT_RST      = 16'hFFFF;
    localparam int          FIFO_DEPTH     = 4;
    localparam int          FIFO_AW        = $clog2(FIFO_DEPTH);

    // Register index of output_limit on the configuration port.
    localparam logic        REG_LIMIT = 1'b0;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_Z      = 8'h5A;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_STEP = 8'h20;

    typedef struct packed {
        logic       bad;
        logic [4:0] val;
    } t_sym;

    // One queue word: an optional decoded byte followed by an optional end status.
    typedef struct packed {
        logic        has_byte;
        logic [7:0]  data;
        logic        has_end;
        logic        ok;
        logic [15:0] count;
    } t_entry;

    localparam logic [5:0] SYM_BAD = 6'h20;

    // Letters A to Z; the top bit marks a letter outside the alphabet.
    localparam logic [5:0] LETTER_VALUE [26] = '{
        6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd1,
        6'd18, 6'd19, 6'd1,  6'd20, 6'd21, 6'd0,  6'd22, 6'd23, 6'd24,
        6'd25, 6'd26, SYM_BAD, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31
    };

    function automatic t_sym sym_of(input logic [7:0] c);
        logic [7:0] u;
        t_sym       s;
        u = (c inside {[CH_LOW_A:CH_LOW_Z]}) ? c - CASE_STEP : c;
        s = t_sym'(SYM_BAD);
        if (c inside {[CH_0:CH_9]}) begin
            s.bad = 1'b0;
            s.val = 5'(c - CH_0);
        end else if (u inside {[CH_A:CH_Z]}) begin
            s = t_sym'(LETTER_VALUE[5'(u - CH_A)]);
        end
        return s;
    endfunction

endpackage

// File: hdl/b32d_front.sv
module b32d_front #(
    parameter int COUNT_BITS = b32d_pkg::COUNT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_char,
    input  logic             i_last,
    input  logic [15:0]      i_limit,
    input  logic             i_full,
    output logic             o_push,
    output b32d_pkg::t_entry o_entry
);
    import b32d_pkg::*;

    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [2:0]            r_gp,    n_gp;
    logic [11:0]           r_buf,   n_buf;
    logic [3:0]            r_fill,  n_fill;
    logic                  r_err,   n_err;
    logic [COUNT_BITS-1:0] r_count, n_count;

    logic                  accept;
    logic                  is_skip;
    t_sym                  sym;
    logic                  active;
    logic                  keep;
    logic [11:0]           buf_sh;
    logic [3:0]            fill_sh;
    logic                  have_byte;
    logic [3:0]            rem_fill;
    logic [7:0]            byte_val;
    logic                  below_limit;
    logic                  emit_byte;
    logic [2:0]            gp_after;
    logic                  bad_group;
    logic [CW-1:0]         count_ext;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        is_skip   = (i_char == CH_LF) || (i_char == CH_DASH) ||
                    (i_char == CH_UNDER) || (i_char == CH_EQ);
        sym       = sym_of(i_char);
        active    = !r_err && !is_skip;
        keep      = active && !sym.bad;

        buf_sh    = {r_buf[6:0], sym.val};
        fill_sh   = r_fill + 4'd5;
        have_byte = fill_sh >= 4'd8;
        rem_fill  = fill_sh - 4'd8;
        byte_val  = 8'(buf_sh >> rem_fill[2:0]);

        // The limit is capped by what the counter can hold.
        below_limit = (CW'(r_count) < CW'(i_limit)) && (r_count != '1);
        emit_byte   = keep && have_byte && below_limit;

        n_err   = r_err || (active && sym.bad);
        n_count = r_count + COUNT_BITS'(emit_byte);
        n_gp    = keep ? r_gp + 3'd1 : r_gp;
        n_buf   = r_buf;
        n_fill  = r_fill;
        if (keep) begin
            if (have_byte) begin
                n_fill = rem_fill;
                n_buf  = buf_sh & 12'((13'd1 << rem_fill) - 13'd1);
            end else begin
                n_fill = fill_sh;
                n_buf  = buf_sh;
            end
        end
        gp_after  = n_gp;
        bad_group = (gp_after == 3'd1) || (gp_after == 3'd3) || (gp_after == 3'd6);
        count_ext = CW'(n_count);

        o_entry.has_byte = emit_byte;
        o_entry.data     = byte_val;
        o_entry.has_end  = i_last;
        o_entry.ok       = !n_err && !bad_group;
        o_entry.count    = count_ext[15:0];
        o_push           = accept && (emit_byte || i_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp    <= '0;
            r_buf   <= '0;
            r_fill  <= '0;
            r_err   <= 1'b0;
            r_count <= '0;
        end else if (accept) begin
            if (i_last) begin
                r_gp    <= '0;
                r_buf   <= '0;
                r_fill  <= '0;
                r_err   <= 1'b0;
                r_count <= '0;
            end else begin
                r_gp    <= n_gp;
                r_buf   <= n_buf;
                r_fill  <= n_fill;
                r_err   <= n_err;
                r_count <= n_count;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_fill <= 4'd7)
        else $error("bit fill left above seven at rest");

endmodule

// File: hdl/b32d_fifo.sv
module b32d_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b32d_pkg::t_entry i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output b32d_pkg::t_entry o_rdata
);
    import b32d_pkg::*;

    t_entry                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     r_wptr;
    logic [FIFO_AW-1:0]     r_rptr;
    logic [FIFO_AW:0]       r_cnt;

    assign o_full  = r_cnt == (FIFO_AW+1)'(FIFO_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(i_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_push |-> !o_full)
        else $error("write into a full queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> !o_empty)
        else $error("read from an empty queue");

endmodule

// File: hdl/b32d_back.sv
module b32d_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  b32d_pkg::t_entry i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_data,
    output logic             o_byte_valid,
    output logic             o_eom,
    output logic             o_ok,
    output logic [15:0]      o_count
);
    import b32d_pkg::*;

    logic        r_valid, n_valid;
    logic        r_phase, n_phase;
    logic [7:0]  r_data,  n_data;
    logic        r_bv,    n_bv;
    logic        r_eom,   n_eom;
    logic        r_ok,    n_ok;
    logic [15:0] r_count, n_count;
    logic        load;

    always_comb begin
        load    = !r_valid || i_ready;
        o_pop   = 1'b0;
        n_valid = r_valid && !i_ready;
        n_phase = r_phase;
        n_data  = r_data;
        n_bv    = r_bv;
        n_eom   = r_eom;
        n_ok    = r_ok;
        n_count = r_count;
        if (load && !i_empty) begin
            n_valid = 1'b1;
            if (i_head.has_byte && !r_phase) begin
                n_data  = i_head.data;
                n_bv    = 1'b1;
                n_eom   = 1'b0;
                n_ok    = 1'b0;
                n_count = '0;
                // A word that also closes the message stays for its end status.
                if (i_head.has_end) begin
                    n_phase = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end else begin
                n_data  = '0;
                n_bv    = 1'b0;
                n_eom   = 1'b1;
                n_ok    = i_head.ok;
                n_count = i_head.count;
                n_phase = 1'b0;
                o_pop   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_bv    <= n_bv;
        r_eom   <= n_eom;
        r_ok    <= n_ok;
        r_count <= n_count;
    end

    assign o_valid      = r_valid;
    assign o_data       = r_data;
    assign o_byte_valid = r_bv;
    assign o_eom        = r_eom;
    assign o_ok         = r_ok;
    assign o_count      = r_count;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> !i_empty && i_head.has_byte && i_head.has_end)
        else $error("split word lost its queue entry");

endmodule

// File: hdl/base32_decoder.sv
// Crockford base32 decoder.
// The input stream carries one ASCII character per word in s_axis_tdata, with
// s_axis_tlast on the final character of a message. The output stream carries
// one decoded byte per word (m_axis_tuser high), and each message closes with
// a status word (m_axis_tlast high, m_axis_tuser low) that holds decode_ok and
// the number of bytes delivered. output_limit sits at APB address 0.
// A character is taken every cycle while the four-entry queue between the
// decode front end and the output stage has room. A result is written into
// the queue and from there loaded into the output register. A character that
// both completes a byte and ends its message yields two output words; every
// other character yields at most one.
// When the receiver stalls, the output register holds its word, the queue
// fills, and s_axis_tready drops once the queue is full.
// Reset clears the message state and the queue and sets output_limit to 65535.
module base32_decoder #(
    parameter int COUNT_BITS = b32d_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] in_char
    input  logic        s_axis_tlast,  // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [7:0] data_byte, [8] decode_ok,
                                       // [24:9] byte_count, [31:25] zero
    output logic        m_axis_tlast,  // end_of_message
    output logic        m_axis_tuser,  // [0] byte_valid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import b32d_pkg::*;

    logic [15:0] r_limit;
    logic        cfg_wr;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    t_entry      wr_entry;
    t_entry      head;
    logic [7:0]  out_data;
    logic        out_ok;
    logic [15:0] out_count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_LIMIT) ? {16'd0, r_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RST;
        end else if (cfg_wr && paddr[2] == REG_LIMIT) begin
            r_limit <= pwdata[15:0];
        end
    end

    b32d_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_char  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_limit (r_limit),
        .i_full  (full),
        .o_push  (push),
        .o_entry (wr_entry)
    );

    b32d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wr_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_rdata (head)
    );

    b32d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (out_data),
        .o_byte_valid (m_axis_tuser),
        .o_eom        (m_axis_tlast),
        .o_ok         (out_ok),
        .o_count      (out_count)
    );

    assign m_axis_tdata = {7'd0, out_count, out_ok, out_data};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser && out_data == 8'd0)
        else $error("status word carries a byte");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> !out_ok && out_count == 16'd0)
        else $error("byte word carries status");

endmodule
